/* rtl/core/mmsl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmsl_pkg
// shared widths and constants for the multi-motor slew limiter
// ----------------------------------------------------------------------------
package mmsl_pkg;

    localparam int MOTORS    = 8;
    localparam int NUM_REGS  = 8;
    localparam int MOTOR_W   = 3;
    localparam int PWM_W     = 8;
    localparam int STEP_W    = 7;
    localparam int CFG_IDX_W = 3;

    // widened pwm for the step arithmetic, one guard bit
    typedef logic signed [PWM_W:0]   t_wide;
    typedef logic signed [PWM_W-1:0] t_pwm;
    typedef logic [STEP_W-1:0]       t_step;
    typedef logic [MOTOR_W-1:0]      t_motor;

    localparam t_wide PWM_EDGE_LOW  = 9'sd10;
    localparam t_wide PWM_EDGE_HIGH = 9'sd90;
    localparam t_wide PWM_FULL      = 9'sd127;

    localparam logic CMD_SET  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

endpackage

/* rtl/core/mmsl_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmsl_in_if
// request channel: set-target and tick transactions
// ----------------------------------------------------------------------------
interface mmsl_in_if;
    logic                        valid;
    logic                        ready;
    logic                        cmd;
    logic [mmsl_pkg::MOTOR_W-1:0] motor_sel;
    logic signed [mmsl_pkg::PWM_W-1:0] target_pwm;
    logic                        bailout;

    modport source (output valid, cmd, motor_sel, target_pwm, bailout, input ready);
    modport sink   (input valid, cmd, motor_sel, target_pwm, bailout, output ready);
endinterface

/* rtl/core/mmsl_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmsl_out_if
// result channel: one drive value per motor transaction
// ----------------------------------------------------------------------------
interface mmsl_out_if;
    logic                        valid;
    logic                        ready;
    logic [mmsl_pkg::MOTOR_W-1:0] motor_out;
    logic signed [mmsl_pkg::PWM_W-1:0] drive_pwm;
    logic                        last_motor;

    modport source (output valid, motor_out, drive_pwm, last_motor, input ready);
    modport sink   (input valid, motor_out, drive_pwm, last_motor, output ready);
endinterface

/* rtl/core/mmsl_cfg_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmsl_cfg_if
// configuration write channel for the per-motor slew steps
// ----------------------------------------------------------------------------
interface mmsl_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [mmsl_pkg::CFG_IDX_W-1:0] index;
    logic [mmsl_pkg::STEP_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/multi_motor_slew_limiter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_motor_slew_limiter
// per-motor pwm slew limiter with dead-band skip, one shared update unit
// ----------------------------------------------------------------------------
// usage
//   i_in  : request transactions. cmd set stores a saturated target for one
//           motor; cmd tick walks every motor in turn
//   o_out : one result transaction per motor on a tick, motor 0 first,
//           last_motor marks the final one; a set request gives no result
//   i_cfg : writes slew step i for motor i, always ready, take it while idle
//   timing: the shared update unit handles one motor per cycle while the
//           output register is free or being emptied; an accepted tick
//           moves the sequencer into its run state and each result is then
//           registered in the output register; after a set request the
//           input stays ready for the next request
//   i_in.ready is low while a tick is walking the motors; a new request may
//           be accepted while the final result still waits in the output
//           register
//   a stall on o_out freezes the walk: the output register holds its result
//           and the next motor is only computed once it is taken
//   reset : targets and present values clear to zero, all steps become 15,
//           no result pending
// ----------------------------------------------------------------------------
module multi_motor_slew_limiter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mmsl_in_if.sink    i_in,
    mmsl_out_if.source o_out,
    mmsl_cfg_if.sink   i_cfg
);
    import mmsl_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    // sequencer
    t_state r_state, n_state;
    t_motor r_idx;
    logic   r_bail;

    // state tables and step registers
    t_pwm  r_target  [MOTORS];
    t_pwm  r_present [MOTORS];
    t_step r_step    [NUM_REGS];

    // output register
    logic   r_out_valid;
    t_motor r_out_motor;
    t_pwm   r_out_pwm;
    logic   r_out_last;

    logic  w_in_acc;
    logic  w_load;
    logic  w_last;
    t_wide w_now, w_req, w_stp, w_base, w_sum, w_next;
    logic  w_rise, w_fall;
    t_pwm  w_drive;
    t_pwm  w_set_tgt;
    logic  w_sel_ok;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_in_acc    = i_in.valid && i_in.ready;

    // advance when the output register is free or being emptied this cycle
    assign w_load = (r_state == S_RUN) && (!r_out_valid || o_out.ready);
    assign w_last = (r_idx == t_motor'(MOTORS - 1));

    // set request: saturate -128 and drop selects past the motor count
    assign w_set_tgt = (i_in.target_pwm == t_pwm'(-128)) ? t_pwm'(-127) : i_in.target_pwm;
    assign w_sel_ok  = ({1'b0, i_in.motor_sel} < (MOTOR_W + 1)'(MOTORS));

    // shared update unit: zone jump, then step and clamp to the target
    always_comb begin
        w_now  = t_wide'(r_present[r_idx]);
        w_req  = t_wide'(r_target[r_idx]);
        w_stp  = t_wide'({2'b00, r_step[r_idx]});
        w_rise = (w_req > w_now);
        w_fall = (w_req < w_now);
        if (w_now < -PWM_EDGE_HIGH) begin
            w_base = w_rise ? -PWM_EDGE_HIGH : -PWM_FULL;
        end else if ((w_now <= PWM_EDGE_LOW) && (w_now >= -PWM_EDGE_LOW)) begin
            w_base = w_rise ? PWM_EDGE_LOW : -PWM_EDGE_LOW;
        end else if (w_now > PWM_EDGE_HIGH) begin
            w_base = w_rise ? PWM_FULL : PWM_EDGE_HIGH;
        end else begin
            w_base = w_now;
        end
        w_sum = w_rise ? (w_base + w_stp) : (w_base - w_stp);
        if (w_rise) begin
            w_next = (w_req < w_sum) ? w_req : w_sum;
        end else if (w_fall) begin
            w_next = (w_req > w_sum) ? w_req : w_sum;
        end else begin
            w_next = w_now;
        end
        // bailout forces every output to zero
        w_drive = r_bail ? '0 : w_next[PWM_W-1:0];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc && (i_in.cmd == CMD_TICK)) n_state = S_RUN;
            end
            S_RUN: begin
                if (w_load && w_last) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_bail      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_in_acc && (i_in.cmd == CMD_TICK)) begin
                r_bail <= i_in.bailout;
                r_idx  <= '0;
            end else if (w_load) begin
                r_idx <= w_last ? '0 : r_idx + t_motor'(1);
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // tables and step registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MOTORS; i++) begin
                r_target[i]  <= '0;
                r_present[i] <= '0;
            end
            for (int i = 0; i < NUM_REGS; i++) begin
                r_step[i] <= t_step'(15);
            end
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_step[i_cfg.index] <= i_cfg.data;
            end
            if (w_in_acc && (i_in.cmd == CMD_SET) && w_sel_ok) begin
                r_target[i_in.motor_sel] <= w_set_tgt;
            end
            if (w_load) begin
                r_present[r_idx] <= w_drive;
                if (r_bail) r_target[r_idx] <= '0;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_motor <= r_idx;
            r_out_pwm   <= w_drive;
            r_out_last  <= w_last;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.motor_out  = r_out_motor;
    assign o_out.drive_pwm  = r_out_pwm;
    assign o_out.last_motor = r_out_last;

    // checks
    a_last_on_final_motor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.last_motor == (o_out.motor_out == t_motor'(MOTORS - 1))))
        else $error("last marker not on the final motor");

    a_idle_idx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_idx == '0))
        else $error("motor index not rewound at end of walk");

    a_no_minus_128: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.drive_pwm != t_pwm'(-128)))
        else $error("drive value outside the saturated range");

endmodule
